// ===== rtl/cxa_pkg.sv =====
// Shared constants, action codes and lane control type for the complex
// accumulator ALU. No dependencies.
package cxa_pkg;

   // Fixed-point format: signed 32-bit words, FRAC_BITS fractional bits
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;

   // Exact sum of two 32x32 products, with headroom
   localparam int SUM_W = 2 * DATA_W + 2;
   // Unsigned divisor c*c + d*d and numerator magnitude
   localparam int DEN_W = 2 * DATA_W;

   // One multiplier bit per cycle, one quotient bit per cycle
   localparam int STEPS = DATA_W;
   localparam int CNT_W = $clog2(STEPS);

   // Action codes
   localparam logic [2:0] ACT_LOAD = 3'd0;
   localparam logic [2:0] ACT_ADD  = 3'd1;
   localparam logic [2:0] ACT_SUB  = 3'd2;
   localparam logic [2:0] ACT_MUL  = 3'd3;
   localparam logic [2:0] ACT_DIV  = 3'd4;

   // Sequencer control shared by the serial lanes
   typedef struct packed {
      logic start;   // load operands, clear partial result
      logic step;    // advance one bit
      logic last;    // this step handles the top (sign) bit
   } lane_ctl_type;

endpackage

// ===== rtl/cxa_mac_lane.sv =====
// Bit-serial signed sum of two products: a*x +/- b*y, one multiplier bit per
// cycle while ctl.step is high. Depends on cxa_pkg.
module cxa_mac_lane (
   input  logic                                  clock,
   input  cxa_pkg::lane_ctl_type                 ctl,
   input  logic signed [cxa_pkg::DATA_W-1:0]     mcand_a,
   input  logic signed [cxa_pkg::DATA_W-1:0]     mplr_a,
   input  logic signed [cxa_pkg::DATA_W-1:0]     mcand_b,
   input  logic signed [cxa_pkg::DATA_W-1:0]     mplr_b,
   input  logic                                  neg_b,
   output logic signed [cxa_pkg::SUM_W-1:0]      sum
);

   logic signed [cxa_pkg::SUM_W-1:0]  mca_ff, mca_in, mcb_ff, mcb_in;
   logic        [cxa_pkg::DATA_W-1:0] mpa_ff, mpa_in, mpb_ff, mpb_in;
   logic signed [cxa_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                              negb_ff, negb_in;
   logic signed [cxa_pkg::SUM_W-1:0]  term_a, term_b, part;

   // Add or subtract the selected partial products; the top bit weighs negative
   always_comb begin
      term_a = mpa_ff[0] ? mca_ff : '0;
      term_b = mpb_ff[0] ? mcb_ff : '0;
      part   = ctl.last ? (sum_ff - term_a) : (sum_ff + term_a);
      mca_in = mca_ff;
      mcb_in = mcb_ff;
      mpa_in = mpa_ff;
      mpb_in = mpb_ff;
      sum_in = sum_ff;
      negb_in = negb_ff;
      if (ctl.start) begin
         mca_in  = {{(cxa_pkg::SUM_W-cxa_pkg::DATA_W){mcand_a[cxa_pkg::DATA_W-1]}}, mcand_a};
         mcb_in  = {{(cxa_pkg::SUM_W-cxa_pkg::DATA_W){mcand_b[cxa_pkg::DATA_W-1]}}, mcand_b};
         mpa_in  = mplr_a;
         mpb_in  = mplr_b;
         sum_in  = '0;
         negb_in = neg_b;
      end else if (ctl.step) begin
         sum_in = (negb_ff ^ ctl.last) ? (part - term_b) : (part + term_b);
         mca_in = mca_ff <<< 1;
         mcb_in = mcb_ff <<< 1;
         mpa_in = mpa_ff >> 1;
         mpb_in = mpb_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      mca_ff  <= mca_in;
      mcb_ff  <= mcb_in;
      mpa_ff  <= mpa_in;
      mpb_ff  <= mpb_in;
      sum_ff  <= sum_in;
      negb_ff <= negb_in;
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/cxa_div_lane.sv =====
// Restoring bit-serial divider: trunc(num * 2^FRAC_BITS / den), clipped to
// 32 bits, one quotient bit per cycle while ctl.step is high. Depends on cxa_pkg.
module cxa_div_lane (
   input  logic                                  clock,
   input  cxa_pkg::lane_ctl_type                 ctl,
   input  logic signed [cxa_pkg::SUM_W-1:0]      num,
   input  logic        [cxa_pkg::DEN_W-1:0]      den,
   output logic signed [cxa_pkg::DATA_W-1:0]     quot,
   output logic                                  sat
);

   localparam int DW = cxa_pkg::DATA_W;
   localparam int NW = cxa_pkg::DEN_W;

   logic [NW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DW-1:0] low_ff, low_in, q_ff, q_in;
   logic          neg_ff, neg_in, ovf_ff, ovf_in;

   logic          num_neg;
   logic [NW-1:0] mag, mag_sh, rem0;
   logic [NW:0]   trial, diff;
   logic [DW:0]   qmag;

   // Split the numerator into sign and magnitude; high part seeds the remainder
   always_comb begin
      num_neg = num[cxa_pkg::SUM_W-1];
      mag     = num_neg ? NW'(-num) : NW'(num);
      rem0    = mag >> (DW - cxa_pkg::FRAC_BITS);
      mag_sh  = mag << cxa_pkg::FRAC_BITS;
      trial   = {rem_ff, low_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
   end

   // Shift in one dividend bit, subtract where it fits
   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      low_in = low_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      if (ctl.start) begin
         rem_in = rem0;
         den_in = den;
         low_in = mag_sh[DW-1:0];
         q_in   = '0;
         neg_in = num_neg;
         ovf_in = (rem0 >= den);
      end else if (ctl.step) begin
         low_in = low_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[NW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[NW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   // Apply sign and clip to the 32-bit range
   always_comb begin
      qmag = ovf_ff ? {1'b1, {DW{1'b0}}} : {1'b0, q_ff};
      if (neg_ff) begin
         sat  = qmag > {2'b01, {(DW-1){1'b0}}};
         quot = sat ? {1'b1, {(DW-1){1'b0}}} : DW'(-qmag);
      end else begin
         sat  = qmag > {2'b00, {(DW-1){1'b1}}};
         quot = sat ? {1'b0, {(DW-1){1'b1}}} : qmag[DW-1:0];
      end
   end

endmodule

// ===== rtl/complex_accumulator_alu.sv =====
// Complex accumulator ALU, signed Q16.16: acc = acc op operand per request.
// Request channel req_*: tdata carries action, operand real and imaginary part.
// Response channel rsp_*: tdata carries the updated accumulator, tuser the
// divide-by-zero and saturated flags. One response per request.
// Path from the accepting edge to response valid: load, add, subtract, unused
// actions and a zero divisor go straight to S_FIN; multiply first runs 32
// serial multiplier steps; divide runs 32 multiplier steps, the S_DLOAD state
// that loads the serial dividers, then 32 divider steps; S_FIN then writes the
// output register once it is free. One request is in work at a time and
// req_tready is high only while idle, so the next waits until S_FIN is left.
// A response stays in its output register until taken; the next request is
// accepted meanwhile and its result waits at the end of its work until the
// output register is free.
// Reset (synchronous, active high) clears the accumulator to zero and drops
// any pending response.
// Depends on cxa_pkg, cxa_mac_lane, cxa_div_lane.
module complex_accumulator_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,    // [2:0] action, [34:3] operand_real,
                                     // [66:35] operand_imag, [71:67] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] result_real, [63:32] result_imag
   output logic [1:0]  rsp_tuser     // [0] divide_by_zero, [1] saturated
);

   localparam int DW = cxa_pkg::DATA_W;

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_DLOAD, S_DIV, S_FIN} state_type;

   typedef struct packed {
      logic signed [DW-1:0] value;
      logic                 sat;
   } clip_type;

   state_type state_ff, state_in;
   logic [cxa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]           act_ff, act_in;
   logic signed [DW-1:0] opr_ff, opr_in, opi_ff, opi_in;
   logic signed [DW-1:0] accr_ff, accr_in, acci_ff, acci_in;
   logic                 dz_ff, dz_in;
   logic                 rvld_ff, rvld_in;
   logic signed [DW-1:0] rre_ff, rre_in, rim_ff, rim_in;
   logic                 rdz_ff, rdz_in, rsat_ff, rsat_in;

   logic [2:0]           req_act;
   logic signed [DW-1:0] req_re, req_im;
   logic                 req_take, out_free, is_div;
   cxa_pkg::lane_ctl_type mac_ctl, div_ctl;
   logic signed [cxa_pkg::SUM_W-1:0] sum_re, sum_im, sum_den;
   logic signed [DW-1:0] ma_re, mb_re, ma_im, mb_im, xa_im, xb_im;
   logic signed [DW-1:0] dq_re, dq_im;
   logic                 dsat_re, dsat_im;
   clip_type             c_re, c_im;
   logic signed [DW-1:0] new_re, new_im;
   logic                 new_sat;

   function automatic clip_type clip_add(input logic signed [DW-1:0] a,
                                         input logic signed [DW-1:0] b,
                                         input logic sub);
      logic signed [DW:0] s;
      clip_type r;
      s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
      r.sat   = s[DW] != s[DW-1];
      r.value = r.sat ? {s[DW], {(DW-1){~s[DW]}}} : s[DW-1:0];
      return r;
   endfunction

   function automatic clip_type clip_prod(input logic signed [cxa_pkg::SUM_W-1:0] v);
      logic signed [cxa_pkg::SUM_W-1:0] f;
      clip_type r;
      f = v >>> cxa_pkg::FRAC_BITS;
      r.sat   = !((&f[cxa_pkg::SUM_W-1:DW-1]) || !(|f[cxa_pkg::SUM_W-1:DW-1]));
      r.value = r.sat ? {f[cxa_pkg::SUM_W-1], {(DW-1){~f[cxa_pkg::SUM_W-1]}}}
                      : f[DW-1:0];
      return r;
   endfunction

   assign req_act  = req_tdata[2:0];
   assign req_re   = req_tdata[34:3];
   assign req_im   = req_tdata[66:35];
   assign req_tready = (state_ff == S_IDLE);
   assign req_take = req_tvalid && req_tready;
   assign out_free = !rvld_ff || rsp_tready;
   assign is_div   = (req_act == cxa_pkg::ACT_DIV);

   // Lane operand routing: multiply vs. divide numerators
   always_comb begin
      ma_re = accr_ff;
      mb_re = acci_ff;
      ma_im = is_div ? acci_ff : accr_ff;
      xa_im = is_div ? req_re  : req_im;
      mb_im = is_div ? accr_ff : acci_ff;
      xb_im = is_div ? req_im  : req_re;
   end

   // Lane sequencing; the dividers load once the products are complete
   always_comb begin
      mac_ctl.start = req_take;
      mac_ctl.step  = (state_ff == S_MAC);
      mac_ctl.last  = (state_ff == S_MAC) && (cnt_ff == cxa_pkg::CNT_W'(cxa_pkg::STEPS-1));
      div_ctl.start = (state_ff == S_DLOAD);
      div_ctl.step  = (state_ff == S_DIV);
      div_ctl.last  = (state_ff == S_DIV) && (cnt_ff == cxa_pkg::CNT_W'(cxa_pkg::STEPS-1));
   end

   cxa_mac_lane u_mac_re (
      .clock, .ctl(mac_ctl),
      .mcand_a(ma_re), .mplr_a(req_re), .mcand_b(mb_re), .mplr_b(req_im),
      .neg_b(!is_div), .sum(sum_re)
   );

   cxa_mac_lane u_mac_im (
      .clock, .ctl(mac_ctl),
      .mcand_a(ma_im), .mplr_a(xa_im), .mcand_b(mb_im), .mplr_b(xb_im),
      .neg_b(is_div), .sum(sum_im)
   );

   cxa_mac_lane u_mac_den (
      .clock, .ctl(mac_ctl),
      .mcand_a(req_re), .mplr_a(req_re), .mcand_b(req_im), .mplr_b(req_im),
      .neg_b(1'b0), .sum(sum_den)
   );

   cxa_div_lane u_div_re (
      .clock, .ctl(div_ctl), .num(sum_re),
      .den(sum_den[cxa_pkg::DEN_W-1:0]), .quot(dq_re), .sat(dsat_re)
   );

   cxa_div_lane u_div_im (
      .clock, .ctl(div_ctl), .num(sum_im),
      .den(sum_den[cxa_pkg::DEN_W-1:0]), .quot(dq_im), .sat(dsat_im)
   );

   // Form the new accumulator value for the item in work
   always_comb begin
      c_re    = clip_prod(sum_re);
      c_im    = clip_prod(sum_im);
      new_re  = accr_ff;
      new_im  = acci_ff;
      new_sat = 1'b0;
      case (act_ff)
         cxa_pkg::ACT_LOAD: begin
            new_re = opr_ff;
            new_im = opi_ff;
         end
         cxa_pkg::ACT_ADD, cxa_pkg::ACT_SUB: begin
            c_re    = clip_add(accr_ff, opr_ff, act_ff == cxa_pkg::ACT_SUB);
            c_im    = clip_add(acci_ff, opi_ff, act_ff == cxa_pkg::ACT_SUB);
            new_re  = c_re.value;
            new_im  = c_im.value;
            new_sat = c_re.sat || c_im.sat;
         end
         cxa_pkg::ACT_MUL: begin
            new_re  = c_re.value;
            new_im  = c_im.value;
            new_sat = c_re.sat || c_im.sat;
         end
         cxa_pkg::ACT_DIV: begin
            if (!dz_ff) begin
               new_re  = dq_re;
               new_im  = dq_im;
               new_sat = dsat_re || dsat_im;
            end
         end
         default: begin
            new_sat = 1'b0;
         end
      endcase
   end

   // Sequencer and output register
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      act_in   = act_ff;
      opr_in   = opr_ff;
      opi_in   = opi_ff;
      dz_in    = dz_ff;
      accr_in  = accr_ff;
      acci_in  = acci_ff;
      rvld_in  = rvld_ff && !rsp_tready;
      rre_in   = rre_ff;
      rim_in   = rim_ff;
      rdz_in   = rdz_ff;
      rsat_in  = rsat_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in = req_act;
               opr_in = req_re;
               opi_in = req_im;
               dz_in  = is_div && (req_re == '0) && (req_im == '0);
               cnt_in = '0;
               if ((req_act == cxa_pkg::ACT_MUL) ||
                   (is_div && !((req_re == '0) && (req_im == '0)))) begin
                  state_in = S_MAC;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (mac_ctl.last) begin
               state_in = (act_ff == cxa_pkg::ACT_DIV) ? S_DLOAD : S_FIN;
            end
         end
         S_DLOAD: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_ctl.last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               accr_in  = new_re;
               acci_in  = new_im;
               rvld_in  = 1'b1;
               rre_in   = new_re;
               rim_in   = new_im;
               rdz_in   = dz_ff;
               rsat_in  = new_sat;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvld_ff  <= 1'b0;
         accr_ff  <= '0;
         acci_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= rvld_in;
         accr_ff  <= accr_in;
         acci_ff  <= acci_in;
      end
      cnt_ff  <= cnt_in;
      act_ff  <= act_in;
      opr_ff  <= opr_in;
      opi_ff  <= opi_in;
      dz_ff   <= dz_in;
      rre_ff  <= rre_in;
      rim_ff  <= rim_in;
      rdz_ff  <= rdz_in;
      rsat_ff <= rsat_in;
   end

   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = {rim_ff, rre_ff};
   assign rsp_tuser  = {rsat_ff, rdz_ff};

endmodule
